[rtl/tccw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Screen geometry, field widths, character and action codes, and the address
// helpers shared by the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int OFS_W  = 11;
    localparam int ACT_W  = 2;
    localparam int SUM_W  = ROW_W + COL_W;

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(TAB_STOP + 1);
    localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd0;

    // Physical row of a visible row, given the current top row.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] vis);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, vis};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // Linear store address of a physical row and a column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        logic [SUM_W-1:0] lin;
        lin = SUM_W'(prow) * SUM_W'(COLS) + SUM_W'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

[rtl/text_console_char_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text-mode screen writer with a character store that has one write and one
// read port, a cursor and a rotating top-row pointer.
//
// Items arrive on the s_ stream: s_tuser carries the action (put, read,
// clear) and s_tdata the character and the cell to read. Every item yields
// one transfer on the m_ stream with the read character and the cursor.
// Work is done one store access per cycle. A printable character writes one
// cell, a tab writes TAB_STOP spaces, a vertical tab writes spaces up to the
// next tab stop, and a read fetches one cell. Each scroll blanks the new
// bottom row with spaces, and a clear item zeroes all ROWS*COLS cells of the
// store. The sustained rate is set by these store writes. After reset a
// clearing pass zeroes the store while s_tready stays low. A finished result
// waits in the output register; the next item is taken meanwhile, and its
// result holds until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: char_code[7:0], read_row[12:8], read_col[19:13].
    input  logic [tccw_pkg::IN_DATA_W-1:0]   s_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [tccw_pkg::ACT_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: cell_char[7:0], cursor_row[12:8], cursor_col[19:13],
    // cursor_offset[30:20].
    output logic [tccw_pkg::OUT_DATA_W-1:0]  m_tdata
);

    typedef enum logic [5:0]
    {
        ST_IDLE   = 6'b000001,
        ST_PUT    = 6'b000010,
        ST_SCROLL = 6'b000100,
        ST_CLEAR  = 6'b001000,
        ST_READ   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic [tccw_pkg::ROW_W-1:0]          cur_row_reg, cur_row_next;
    logic [tccw_pkg::COL_W-1:0]          cur_col_reg, cur_col_next;
    logic [tccw_pkg::ROW_W-1:0]          top_row_reg, top_row_next;
    logic [tccw_pkg::PH_W-1:0]           tab_ph_reg, tab_ph_next;
    logic [tccw_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [tccw_pkg::CHAR_W-1:0]         wr_char_reg, wr_char_next;
    logic [tccw_pkg::COL_W-1:0]          sweep_col_reg, sweep_col_next;
    logic [tccw_pkg::ADDR_W-1:0]         clr_addr_reg, clr_addr_next;
    logic                                clr_report_reg, clr_report_next;
    logic                                in_range_reg, in_range_next;
    logic [tccw_pkg::CHAR_W-1:0]         cell_reg, cell_next;
    logic                                m_valid_reg, m_valid_next;
    logic [tccw_pkg::OUT_DATA_W-1:0]     m_data_reg, m_data_next;
    logic [tccw_pkg::CHAR_W-1:0]         rd_data_reg;

    logic [tccw_pkg::CHAR_W-1:0]         mem [tccw_pkg::DEPTH];
    logic                                mem_we;
    logic [tccw_pkg::ADDR_W-1:0]         mem_waddr;
    logic [tccw_pkg::CHAR_W-1:0]         mem_wdata;
    logic                                mem_re;
    logic [tccw_pkg::ADDR_W-1:0]         mem_raddr;

    logic [tccw_pkg::ACT_W-1:0]          in_action;
    logic [tccw_pkg::CHAR_W-1:0]         in_char;
    logic [tccw_pkg::ROW_W-1:0]          in_row;
    logic [tccw_pkg::COL_W-1:0]          in_col;
    logic                                in_rng;
    logic [tccw_pkg::ROW_W-1:0]          top_adv;
    logic [tccw_pkg::ROW_W-1:0]          bottom_row;
    logic [tccw_pkg::SUM_W-1:0]          offset_sum;

    assign in_action = s_tuser;
    assign in_char   = s_tdata[7:0];
    assign in_row    = s_tdata[12:8];
    assign in_col    = s_tdata[19:13];
    assign in_rng    = (in_row < tccw_pkg::ROW_W'(tccw_pkg::ROWS))
                    && (in_col < tccw_pkg::COL_W'(tccw_pkg::COLS));

    assign top_adv    = (top_row_reg == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1))
                      ? '0 : top_row_reg + 1'b1;
    assign bottom_row = (top_row_reg == '0)
                      ? tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1) : top_row_reg - 1'b1;
    assign offset_sum = tccw_pkg::SUM_W'(cur_row_reg) * tccw_pkg::SUM_W'(tccw_pkg::COLS)
                      + tccw_pkg::SUM_W'(cur_col_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        top_row_next    = top_row_reg;
        tab_ph_next     = tab_ph_reg;
        cnt_next        = cnt_reg;
        wr_char_next    = wr_char_reg;
        sweep_col_next  = sweep_col_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        in_range_next   = in_range_reg;
        cell_next       = cell_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = tccw_pkg::cell_addr(tccw_pkg::phys_row(top_row_reg, cur_row_reg),
                                              cur_col_reg);
        mem_wdata       = wr_char_reg;
        mem_re          = 1'b0;
        mem_raddr       = tccw_pkg::cell_addr(tccw_pkg::phys_row(top_row_reg, in_row),
                                              in_col);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cell_next = tccw_pkg::CH_ZERO;
                    case (in_action)
                        tccw_pkg::ACT_PUT:
                        begin
                            case (in_char)
                                tccw_pkg::CH_NL:
                                begin
                                    cur_col_next = '0;
                                    tab_ph_next  = '0;
                                    if (cur_row_reg == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1))
                                    begin
                                        top_row_next   = top_adv;
                                        sweep_col_next = '0;
                                        cnt_next       = '0;
                                        state_next     = ST_SCROLL;
                                    end
                                    else
                                    begin
                                        cur_row_next = cur_row_reg + 1'b1;
                                        state_next   = ST_DONE;
                                    end
                                end
                                tccw_pkg::CH_CR:
                                begin
                                    cur_col_next = '0;
                                    tab_ph_next  = '0;
                                    state_next   = ST_DONE;
                                end
                                tccw_pkg::CH_TAB:
                                begin
                                    cnt_next     = tccw_pkg::CNT_W'(tccw_pkg::TAB_STOP);
                                    wr_char_next = tccw_pkg::CH_SPACE;
                                    state_next   = ST_PUT;
                                end
                                tccw_pkg::CH_VT:
                                begin
                                    cnt_next     = tccw_pkg::CNT_W'(tccw_pkg::TAB_STOP)
                                                 - tccw_pkg::CNT_W'(tab_ph_reg);
                                    wr_char_next = tccw_pkg::CH_SPACE;
                                    state_next   = ST_PUT;
                                end
                                default:
                                begin
                                    cnt_next     = tccw_pkg::CNT_W'(1);
                                    wr_char_next = in_char;
                                    state_next   = ST_PUT;
                                end
                            endcase
                        end
                        tccw_pkg::ACT_READ:
                        begin
                            mem_re        = in_rng;
                            in_range_next = in_rng;
                            state_next    = ST_READ;
                        end
                        tccw_pkg::ACT_CLEAR:
                        begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            top_row_next    = '0;
                            tab_ph_next     = '0;
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cur_col_reg == tccw_pkg::COL_W'(tccw_pkg::COLS - 1))
                begin
                    cur_col_next = '0;
                    tab_ph_next  = '0;
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                    tab_ph_next  = (tab_ph_reg == tccw_pkg::PH_W'(tccw_pkg::TAB_STOP - 1))
                                 ? '0 : tab_ph_reg + 1'b1;
                end
                if ((cur_col_reg == tccw_pkg::COL_W'(tccw_pkg::COLS - 1))
                    && (cur_row_reg == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)))
                begin
                    top_row_next   = top_adv;
                    sweep_col_next = '0;
                    state_next     = ST_SCROLL;
                end
                else
                begin
                    if (cur_col_reg == tccw_pkg::COL_W'(tccw_pkg::COLS - 1))
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                    if (cnt_reg == tccw_pkg::CNT_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCROLL:
            begin
                mem_we    = 1'b1;
                mem_waddr = tccw_pkg::cell_addr(bottom_row, sweep_col_reg);
                mem_wdata = tccw_pkg::CH_SPACE;
                if (sweep_col_reg == tccw_pkg::COL_W'(tccw_pkg::COLS - 1))
                begin
                    state_next = (cnt_reg == '0) ? ST_DONE : ST_PUT;
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 1'b1;
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = tccw_pkg::CH_ZERO;
                if (clr_addr_reg == tccw_pkg::ADDR_W'(tccw_pkg::DEPTH - 1))
                begin
                    clr_report_next = 1'b0;
                    state_next      = clr_report_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                cell_next  = in_range_reg ? rd_data_reg : tccw_pkg::CH_ZERO;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, offset_sum[tccw_pkg::OFS_W-1:0],
                                    cur_col_reg, cur_row_reg, cell_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_row_reg    <= '0;
            tab_ph_reg     <= '0;
            cnt_reg        <= '0;
            sweep_col_reg  <= '0;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_row_reg    <= top_row_next;
            tab_ph_reg     <= tab_ph_next;
            cnt_reg        <= cnt_next;
            sweep_col_reg  <= sweep_col_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_char_reg  <= wr_char_next;
        in_range_reg <= in_range_next;
        cell_reg     <= cell_next;
        m_data_reg   <= m_data_next;
    end

    // The store is read only while no write is in progress, so no forwarding
    // is needed between the two ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg < tccw_pkg::ROW_W'(tccw_pkg::ROWS))
        && (cur_col_reg < tccw_pkg::COL_W'(tccw_pkg::COLS))
        && (top_row_reg < tccw_pkg::ROW_W'(tccw_pkg::ROWS)))
        else $error("Cursor or top row left the screen.");

    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("Store read and write in the same cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == tccw_pkg::ACT_READ)) |=> (state_reg == ST_READ))
        else $error("Read item did not wait for store data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && m_valid_reg && !m_tready |=> (state_reg == ST_DONE))
        else $error("Result dropped while the receiver stalled.");

endmodule
